[rtl/wfpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_pkg
// Shared codes and controller/datapath interface types for the worst-fit
// partition allocator.
// ----------------------------------------------------------------------------
package wfpa_pkg;

  // request kinds (s_tuser)
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_ALLOC  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  // result status codes (m_tuser)
  localparam logic [2:0] ST_LOADED = 3'd0;
  localparam logic [2:0] ST_ALLOC  = 3'd1;
  localparam logic [2:0] ST_NOFIT  = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 96;

  // controller -> datapath
  typedef struct packed {
    logic latch;       // take a new request
    logic load;        // append a free hole
    logic rd_issue;    // read the addressed entry
    logic rd_capture;  // capture read data into the result
    logic scan_step;   // walk the table for fit / report
    logic decide;      // grant, refuse or miss
    logic shift_step;  // move entries up by one
    logic insert;      // write the leftover hole
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_alloc;
    logic scan_done;
    logic split_go;
    logic shift_done;
  } dp_stat_t;

endpackage

[rtl/worst_fit_partition_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator
// Ordered block table with worst-fit allocation, hole loading, entry readback
// and free-space report.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  s_*      in   tuser: req_type; tdata: request_size, entry_index
//  m_*      out  tuser: status;   tdata: index, pid, sizes, flags, report, count
//
// Load appends one entry unless the table is full. Read issues a table read,
// then captures it. Report walks every entry. Allocate walks every entry, then,
// when a leftover is split off, moves the entries above the chosen block up by
// one and inserts the leftover; the table memory (one read, one write per cycle)
// sets both the scan and the shift-up walk. Reset clears the entry count, id
// counter, output valid and controller state, not the table; table contents are
// undefined until written. One beat is in flight at a time; a finished
// result parks in the output register and a stalled m_tready holds it.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  input  logic [23:0] s_tdata,   // [15:0] request_size, [21:16] entry_index
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [2:0]  m_tuser,   // [2:0] status
  // [5:0] chosen_index, [13:6] process_id, [29:14] block_size_out,
  // [45:30] remaining_size, [46] entry_used, [68:47] total_free,
  // [84:69] largest_hole, [91:85] block_count_out
  output logic [95:0] m_tdata
);

  wfpa_pkg::ctl_cmd_t cmd;
  wfpa_pkg::dp_stat_t stat;

  logic        out_load;
  logic        out_free;
  logic [2:0]  res_status;
  logic [5:0]  res_chosen;
  logic [7:0]  res_pid;
  logic [15:0] res_bsize;
  logic [15:0] res_rem;
  logic        res_used;
  logic [21:0] res_total;
  logic [15:0] res_largest;
  logic [6:0]  res_count;

  assign out_free = !m_tvalid || m_tready;

  wfpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (s_tready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  wfpa_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .in_kind     (s_tuser),
    .in_size     (s_tdata[15:0]),
    .in_index    (s_tdata[21:16]),
    .stat        (stat),
    .res_status  (res_status),
    .res_chosen  (res_chosen),
    .res_pid     (res_pid),
    .res_bsize   (res_bsize),
    .res_rem     (res_rem),
    .res_used    (res_used),
    .res_total   (res_total),
    .res_largest (res_largest),
    .res_count   (res_count)
  );

  // output register: loaded only when empty or draining
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {4'd0, res_count, res_largest, res_total, res_used, res_rem,
                  res_bsize, res_pid, res_chosen};
    end
  end

  // a result only lands in a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free) else $error("result overwrote a pending beat");

  // one request at a time: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("second request taken");

  // table never holds more than its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    32'(res_count) <= MAX_BLOCKS) else $error("entry count overflow");

endmodule

[rtl/wfpa_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_datapath
// Block table memory, entry count, id counter, scan and shift logic.
// ----------------------------------------------------------------------------
module wfpa_datapath #(
  parameter int MAX_BLOCKS = 64,
  parameter int SIZE_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wfpa_pkg::ctl_cmd_t   cmd,
  input  logic [1:0]           in_kind,
  input  logic [15:0]          in_size,
  input  logic [5:0]           in_index,
  output wfpa_pkg::dp_stat_t   stat,
  output logic [2:0]           res_status,
  output logic [5:0]           res_chosen,
  output logic [7:0]           res_pid,
  output logic [15:0]          res_bsize,
  output logic [15:0]          res_rem,
  output logic                 res_used,
  output logic [21:0]          res_total,
  output logic [15:0]          res_largest,
  output logic [6:0]           res_count
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W  = SIZE_BITS + IDX_W;
  localparam int WORD_W = SIZE_BITS + 9;

  // word: owner, used, size (size in the low bits)
  logic [WORD_W-1:0]    mem [MAX_BLOCKS];
  logic [WORD_W-1:0]    rdata;

  logic [1:0]           kind;
  logic [SIZE_BITS-1:0] req;
  logic [5:0]           ridx;
  logic                 ridx_ok;
  logic [CNT_W-1:0]     count;
  logic [7:0]           reqctr;
  logic [CNT_W-1:0]     ptr;
  logic                 pend;
  logic [IDX_W-1:0]     paddr;
  logic [IDX_W-1:0]     best;
  logic [SIZE_BITS-1:0] best_size;
  logic                 found;
  logic [SUM_W-1:0]     total;
  logic [SIZE_BITS-1:0] largest;

  logic                 re, we;
  logic [IDX_W-1:0]     raddr, waddr;
  logic [WORD_W-1:0]    wdata;
  logic                 full;
  logic [SIZE_BITS-1:0] left;
  logic [CNT_W-1:0]     best1;
  logic                 scan_go, shift_go;
  logic [SIZE_BITS-1:0] r_size;
  logic                 r_used;

  assign full     = (count == CNT_W'(MAX_BLOCKS));
  assign left     = best_size - req;
  assign best1    = CNT_W'(best) + CNT_W'(1);
  assign scan_go  = (ptr < count);
  assign shift_go = (ptr > best1);
  assign r_size   = rdata[SIZE_BITS-1:0];
  assign r_used   = rdata[SIZE_BITS];

  assign stat.is_alloc   = (kind == wfpa_pkg::KIND_ALLOC);
  assign stat.scan_done  = !scan_go && !pend;
  assign stat.split_go   = found && (left != '0) && !full;
  assign stat.shift_done = !shift_go && !pend;

  always_comb begin
    re    = 1'b0;
    raddr = '0;
    if (cmd.rd_issue) begin
      // data only used when the index is below the count
      re    = 1'b1;
      raddr = IDX_W'(ridx);
    end else if (cmd.scan_step) begin
      re    = scan_go;
      raddr = ptr[IDX_W-1:0];
    end else if (cmd.shift_step) begin
      re    = shift_go;
      raddr = IDX_W'(ptr - CNT_W'(1));
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.load) begin
      we    = !full;
      waddr = count[IDX_W-1:0];
      wdata = {8'd0, 1'b0, req};
    end else if (cmd.decide) begin
      we    = found && ((left == '0) || !full);
      waddr = best;
      wdata = {reqctr, 1'b1, req};
    end else if (cmd.shift_step) begin
      we    = pend;
      waddr = paddr;
      wdata = rdata;
    end else if (cmd.insert) begin
      we    = 1'b1;
      waddr = best1[IDX_W-1:0];
      wdata = {8'd0, 1'b0, left};
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      reqctr <= '0;
      pend   <= 1'b0;
    end else begin
      if (cmd.latch) begin
        pend <= 1'b0;
        if (in_kind == wfpa_pkg::KIND_ALLOC) begin
          reqctr <= reqctr + 8'd1;
        end
      end
      if (cmd.load && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.insert) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.scan_step) begin
        pend <= scan_go;
      end
      if (cmd.shift_step) begin
        pend <= shift_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind        <= in_kind;
      req         <= SIZE_BITS'(in_size);
      ridx        <= in_index;
      ptr         <= '0;
      found       <= 1'b0;
      best        <= '0;
      best_size   <= '0;
      total       <= '0;
      largest     <= '0;
      res_status  <= wfpa_pkg::ST_DONE;
      res_chosen  <= '0;
      res_pid     <= (in_kind == wfpa_pkg::KIND_ALLOC) ? reqctr + 8'd1 : 8'd0;
      res_bsize   <= '0;
      res_rem     <= '0;
      res_used    <= 1'b0;
    end
    if (cmd.load) begin
      res_status <= full ? wfpa_pkg::ST_FULL : wfpa_pkg::ST_LOADED;
      if (!full) begin
        res_chosen <= 6'(count);
        res_bsize  <= 16'(req);
      end
    end
    if (cmd.rd_issue) begin
      ridx_ok <= (32'(ridx) < 32'(count));
    end
    if (cmd.rd_capture) begin
      res_chosen <= ridx;
      if (ridx_ok) begin
        res_pid   <= rdata[WORD_W-1:SIZE_BITS+1];
        res_bsize <= 16'(r_size);
        res_used  <= r_used;
      end
    end
    if (cmd.scan_step) begin
      if (scan_go) begin
        paddr <= ptr[IDX_W-1:0];
        ptr   <= ptr + CNT_W'(1);
      end
      if (pend && !r_used) begin
        total <= total + SUM_W'(r_size);
        if (r_size > largest) begin
          largest <= r_size;
        end
        if ((r_size >= req) && (!found || (r_size > best_size))) begin
          found     <= 1'b1;
          best      <= paddr;
          best_size <= r_size;
        end
      end
    end
    if (cmd.decide) begin
      ptr <= count;
      if (!found) begin
        res_status <= wfpa_pkg::ST_NOFIT;
      end else if ((left != '0) && full) begin
        res_status <= wfpa_pkg::ST_FULL;
      end else begin
        res_status <= wfpa_pkg::ST_ALLOC;
        res_chosen <= 6'(best);
        res_bsize  <= 16'(best_size);
        res_rem    <= 16'(left);
      end
    end
    if (cmd.shift_step && shift_go) begin
      paddr <= ptr[IDX_W-1:0];
      ptr   <= ptr - CNT_W'(1);
    end
  end

  assign res_total   = (kind == wfpa_pkg::KIND_REPORT) ? 22'(total) : 22'd0;
  assign res_largest = (kind == wfpa_pkg::KIND_REPORT) ? 16'(largest) : 16'd0;
  assign res_count   = 7'(count);

endmodule

[rtl/wfpa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfpa_ctrl
// Sequencer for load, read, scan, grant, shift and insert steps.
// ----------------------------------------------------------------------------
module wfpa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_kind,
  input  logic                out_free,
  input  wfpa_pkg::dp_stat_t  stat,
  output logic                in_ready,
  output logic                out_load,
  output wfpa_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LOAD   = 9'b000000010,
    S_RDREQ  = 9'b000000100,
    S_RDWAIT = 9'b000001000,
    S_SCAN   = 9'b000010000,
    S_DECIDE = 9'b000100000,
    S_SHIFT  = 9'b001000000,
    S_INSERT = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          case (in_kind)
            wfpa_pkg::KIND_LOAD: state_next = S_LOAD;
            wfpa_pkg::KIND_READ: state_next = S_RDREQ;
            default:             state_next = S_SCAN;
          endcase
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_DONE;
      end
      S_RDREQ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_RDWAIT;
      end
      S_RDWAIT: begin
        cmd.rd_capture = 1'b1;
        state_next     = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = stat.is_alloc ? S_DECIDE : S_DONE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.split_go ? S_SHIFT : S_DONE;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_done) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[bench/worst_fit_partition_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worst_fit_partition_allocator_tb
// Self-checking bench for the worst-fit allocator. A directed table of loads,
// allocations, reads and reports comes first, then random request streams.
// Every result beat is compared field by field with an in-bench table model.
// ----------------------------------------------------------------------------
module worst_fit_partition_allocator_tb;

  localparam int TBL_DEPTH = 64;
  localparam int N_RANDOM  = 1625;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  // field view of one result beat
  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  chosen;
    logic [7:0]  pid;
    logic [15:0] bsize;
    logic [15:0] rem;
    logic        used;
    logic [21:0] total;
    logic [15:0] largest;
    logic [6:0]  count;
  } alloc_res_t;

  // directed row: request plus an optional typed-in answer
  typedef struct {
    logic [1:0]  kind;
    logic [15:0] size;
    logic [5:0]  idx;
    bit          fixed;
    alloc_res_t  res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [1:0]  s_tuser;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [2:0]  m_tuser;
  logic [95:0] m_tdata;

  worst_fit_partition_allocator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // model of the table
  logic [15:0] tbl_size  [TBL_DEPTH];
  logic        tbl_used  [TBL_DEPTH];
  logic [7:0]  tbl_owner [TBL_DEPTH];
  int          tbl_count;
  logic [7:0]  pid_ctr;

  alloc_res_t  expected_q [$];
  int          fail_count;
  bit          send_done;
  bit          long_hold;   // sink holds off while set, until its hold counter runs out
  longint      cycle_cnt;

  function automatic alloc_res_t predict_alloc(logic [1:0] kind, logic [15:0] size,
                                               logic [5:0] idx);
    alloc_res_t r;
    bit         found;
    int         best;
    logic [15:0] best_sz;
    logic [16:0] left;
    logic [31:0] sum;
    r = '0;
    found = 0;
    best = 0;
    best_sz = '0;
    sum = '0;
    r.status = wfpa_pkg::ST_DONE;
    case (kind)
      wfpa_pkg::KIND_LOAD: begin
        if (tbl_count >= TBL_DEPTH) begin
          r.status = wfpa_pkg::ST_FULL;
        end else begin
          tbl_size[tbl_count]  = size;
          tbl_used[tbl_count]  = 1'b0;
          tbl_owner[tbl_count] = '0;
          r.chosen = tbl_count[5:0];
          r.bsize  = size;
          tbl_count++;
          r.status = wfpa_pkg::ST_LOADED;
        end
      end
      wfpa_pkg::KIND_ALLOC: begin
        pid_ctr = pid_ctr + 8'd1;
        r.pid = pid_ctr;
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_used[i] && tbl_size[i] >= size && (!found || tbl_size[i] > best_sz)) begin
            found = 1;
            best = i;
            best_sz = tbl_size[i];
          end
        end
        if (!found) begin
          r.status = wfpa_pkg::ST_NOFIT;
        end else begin
          left = best_sz - size;
          if (left != 0 && tbl_count >= TBL_DEPTH) begin
            r.status = wfpa_pkg::ST_FULL;
          end else begin
            tbl_used[best]  = 1'b1;
            tbl_size[best]  = size;
            tbl_owner[best] = pid_ctr;
            if (left != 0) begin
              for (int i = tbl_count; i > best + 1; i--) begin
                tbl_size[i]  = tbl_size[i-1];
                tbl_used[i]  = tbl_used[i-1];
                tbl_owner[i] = tbl_owner[i-1];
              end
              tbl_size[best+1]  = left[15:0];
              tbl_used[best+1]  = 1'b0;
              tbl_owner[best+1] = '0;
              tbl_count++;
            end
            r.status = wfpa_pkg::ST_ALLOC;
            r.chosen = best[5:0];
            r.bsize  = best_sz;
            r.rem    = left[15:0];
          end
        end
      end
      wfpa_pkg::KIND_REPORT: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (!tbl_used[i]) begin
            sum = sum + tbl_size[i];
            if (tbl_size[i] > r.largest) r.largest = tbl_size[i];
          end
        end
        r.total = sum[21:0];
      end
      default: begin
        r.chosen = idx;
        if (idx < tbl_count) begin
          r.pid   = tbl_owner[idx];
          r.bsize = tbl_size[idx];
          r.used  = tbl_used[idx];
        end
      end
    endcase
    r.count = tbl_count[6:0];
    return r;
  endfunction

  function automatic alloc_res_t fixed_res(logic [2:0] st, logic [5:0] ch, logic [7:0] pid,
                                           logic [15:0] bs, logic [15:0] rm, logic [6:0] cnt);
    alloc_res_t r;
    r = '0;
    r.status = st;
    r.chosen = ch;
    r.pid    = pid;
    r.bsize  = bs;
    r.rem    = rm;
    r.count  = cnt;
    return r;
  endfunction

  // one request beat: random gap, present at falling edge, hold until taken;
  // with no gap tvalid stays high into the next beat
  task automatic send_req(logic [1:0] kind, logic [15:0] size, logic [5:0] idx,
                          bit fixed, alloc_res_t want);
    alloc_res_t pred;
    int gap;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, idx, size};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = predict_alloc(kind, size, idx);
    if (fixed && pred !== want) begin
      $display("%0t: directed row disagrees with model: typed %h model %h",
               $time, want, pred);
      fail_count++;
    end
    expected_q.push_back(pred);
    @(negedge clk);
  endtask

  // wait for every outstanding result, then let the block settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic random_req(int mode);
    logic [1:0]  k;
    logic [15:0] sz;
    logic [5:0]  ix;
    int p;
    p = $urandom_range(0, 99);
    ix = $urandom_range(0, 99) < 80 ? 6'($urandom_range(0, tbl_count > 0 ? tbl_count : 0))
                                    : 6'($urandom);
    if (mode == 0) begin
      // steady mix of small holes and requests
      if (p < 30) k = wfpa_pkg::KIND_LOAD;
      else if (p < 70) k = wfpa_pkg::KIND_ALLOC;
      else if (p < 82) k = wfpa_pkg::KIND_REPORT;
      else k = wfpa_pkg::KIND_READ;
      sz = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    end else begin
      // extremes: large/zero sizes, table pressed toward full
      if (p < 50) k = wfpa_pkg::KIND_LOAD;
      else if (p < 80) k = wfpa_pkg::KIND_ALLOC;
      else if (p < 90) k = wfpa_pkg::KIND_REPORT;
      else k = wfpa_pkg::KIND_READ;
      case ($urandom_range(0, 3))
        0: sz = 16'hFFFF;
        1: sz = 16'h0000;
        2: sz = 16'($urandom);
        default: sz = 16'($urandom_range(0, 16));
      endcase
    end
    send_req(k, sz, ix, 1'b0, '0);
  endtask

  dir_row_t dir_tbl [$];

  initial begin
    dir_row_t row;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tuser   = '0;
    s_tdata   = '0;
    fail_count = 0;
    send_done = 0;
    long_hold = 0;
    tbl_count = 0;
    pid_ctr   = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed rows; typed answers only where obvious
    dir_tbl = '{
      '{wfpa_pkg::KIND_REPORT, 16'h0000, 6'd0,  1,
        fixed_res(wfpa_pkg::ST_DONE, 6'd0, 8'd0, 16'd0, 16'd0, 7'd0)},
      '{wfpa_pkg::KIND_READ,   16'h0000, 6'd63, 1,
        fixed_res(wfpa_pkg::ST_DONE, 6'd63, 8'd0, 16'd0, 16'd0, 7'd0)},
      '{wfpa_pkg::KIND_ALLOC,  16'h0000, 6'd0,  1,
        fixed_res(wfpa_pkg::ST_NOFIT, 6'd0, 8'd1, 16'd0, 16'd0, 7'd0)},
      '{wfpa_pkg::KIND_LOAD,   16'hFFFF, 6'd0,  1,
        fixed_res(wfpa_pkg::ST_LOADED, 6'd0, 8'd0, 16'hFFFF, 16'd0, 7'd1)},
      '{wfpa_pkg::KIND_LOAD,   16'h0000, 6'd0,  1,
        fixed_res(wfpa_pkg::ST_LOADED, 6'd1, 8'd0, 16'd0, 16'd0, 7'd2)},
      '{wfpa_pkg::KIND_LOAD,   16'd100,  6'd0,  1,
        fixed_res(wfpa_pkg::ST_LOADED, 6'd2, 8'd0, 16'd100, 16'd0, 7'd3)},
      '{wfpa_pkg::KIND_LOAD,   16'd100,  6'd0,  0, '0},
      '{wfpa_pkg::KIND_ALLOC,  16'd100,  6'd0,  0, '0},
      '{wfpa_pkg::KIND_ALLOC,  16'd40,   6'd0,  0, '0},
      '{wfpa_pkg::KIND_ALLOC,  16'd0,    6'd0,  0, '0},
      '{wfpa_pkg::KIND_ALLOC,  16'hFFFF, 6'd0,  0, '0},
      '{wfpa_pkg::KIND_REPORT, 16'h0000, 6'd0,  0, '0},
      '{wfpa_pkg::KIND_READ,   16'h0000, 6'd0,  0, '0},
      '{wfpa_pkg::KIND_READ,   16'h0000, 6'd1,  0, '0},
      '{wfpa_pkg::KIND_READ,   16'h0000, 6'd2,  0, '0},
      '{wfpa_pkg::KIND_READ,   16'h0000, 6'd40, 0, '0},
      '{wfpa_pkg::KIND_ALLOC,  16'd500,  6'd0,  0, '0},
      '{wfpa_pkg::KIND_ALLOC,  16'd30,   6'd0,  0, '0},
      '{wfpa_pkg::KIND_REPORT, 16'h0000, 6'd0,  0, '0},
      '{wfpa_pkg::KIND_READ,   16'hFFFF, 6'd4,  0, '0}
    };
    foreach (dir_tbl[i]) begin
      row = dir_tbl[i];
      send_req(row.kind, row.size, row.idx, row.fixed, row.res);
    end

    // sender pause until everything is back
    drain_results();

    // sink stalls long while requests keep coming
    long_hold = 1;
    for (int i = 0; i < 25; i++) random_req(0);
    long_hold = 0;

    for (int i = 0; i < N_RANDOM; i++) begin
      random_req((i % 400) > 300 ? 1 : 0);
      // periodic reuse of pid wraparound and table fill comes naturally
    end

    drain_results();
    send_done = 1;
  end

  // sink: random back-pressure, with one long hold-off counted here
  initial begin
    int hold;
    m_tready = 1'b0;
    hold = 0;
    @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold && hold < 400) begin
        hold++;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(5, 40)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    alloc_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[5:0], m_tdata[13:6], m_tdata[29:14], m_tdata[45:30],
              m_tdata[46], m_tdata[68:47], m_tdata[84:69], m_tdata[91:85]};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
        if (got.chosen !== want.chosen)
          $display("%0t: chosen_index exp %0d got %0d", $time, want.chosen, got.chosen);
        if (got.pid !== want.pid)
          $display("%0t: process_id exp %0d got %0d", $time, want.pid, got.pid);
        if (got.bsize !== want.bsize)
          $display("%0t: block_size exp %0d got %0d", $time, want.bsize, got.bsize);
        if (got.rem !== want.rem)
          $display("%0t: remaining exp %0d got %0d", $time, want.rem, got.rem);
        if (got.used !== want.used)
          $display("%0t: entry_used exp %0d got %0d", $time, want.used, got.used);
        if (got.total !== want.total)
          $display("%0t: total_free exp %0d got %0d", $time, want.total, got.total);
        if (got.largest !== want.largest)
          $display("%0t: largest_hole exp %0d got %0d", $time, want.largest, got.largest);
        if (got.count !== want.count)
          $display("%0t: block_count exp %0d got %0d", $time, want.count, got.count);
        if (got !== want) fail_count++;
      end
    end
  end

  // finish or time out
  initial begin
    cycle_cnt = 0;
    while (!send_done && cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    if (!send_done) begin
      $display("TEST FAILED");
    end else if (fail_count == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
